// ----- rtl/core/mutr_pkg.sv -----
`default_nettype none
package mutr_pkg;

    localparam int MAX_WIDTH_DEF = 256;

    localparam logic [8:0]  GRID_WIDTH_RST  = 9'd256;
    localparam logic [15:0] GRID_HEIGHT_RST = 16'd256;

    localparam logic CFG_GRID_WIDTH  = 1'b0;
    localparam logic CFG_GRID_HEIGHT = 1'b1;

    localparam int CFG_DATA_W = 16;
    localparam int ACC_W      = 51;
    localparam int QMAG_W     = 50;
    localparam int DEN_W      = 18;
    localparam int PROD_W     = 49;

    typedef struct packed {
        logic signed [31:0] u_value;
        logic               u_mask;
        logic               t_mask;
        logic [15:0]        weight_here;
        logic [15:0]        weight_north;
        logic [15:0]        weight_east;
        logic [15:0]        weight_northeast;
    } in_item_t;

    typedef struct packed {
        logic signed [31:0] t_value;
        logic [15:0]        row_index;
        logic [7:0]         col_index;
        logic               last_of_row;
    } out_item_t;

endpackage
`default_nettype wire

// ----- rtl/core/mutr_ram.sv -----
`default_nettype none
module mutr_ram #(
    parameter int WIDTH = 33,
    parameter int DEPTH = 256
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        rdata <= mem_reg[raddr];
    end

endmodule
`default_nettype wire

// ----- rtl/core/masked_ugrid_to_tgrid_remap_unit.sv -----
// Masked 2x2 stencil remap from the velocity grid to the target grid.
// The input channel (in_valid, in_stall, in_data) carries one velocity point per
// transaction in row order. The output channel (out_valid, out_stall, out_data)
// carries the target points: the point of column c-1 leaves after input column c,
// and the zero point of the last column follows at once, so an input gives 0, 1 or 2
// output transactions. A line buffer RAM of MAX_WIDTH entries holds the row above.
// An input that yields only zero results goes from S_READ straight to S_EMIT.
// A computed point passes one RAM read, a multiply-accumulate of the four stencil
// terms on one shared 17x32 multiplier, and a bit-serial restoring divider.
// One input is in flight at a time; the next is accepted once both output slots
// are empty. After reset the block clears the line buffer, one entry per cycle,
// over all MAX_WIDTH entries with in_stall high; configuration writes are taken at any
// time and restart the raster at row 0, column 0. When the receiver stalls, the
// results wait in a two-entry output buffer and the input side stalls.
`default_nettype none
module masked_ugrid_to_tgrid_remap_unit #(
    parameter int MAX_WIDTH = mutr_pkg::MAX_WIDTH_DEF
) (
    input  wire logic                                clk,
    input  wire logic                                rst_n,
    input  wire logic                                in_valid,
    output logic                                     in_stall,
    input  wire mutr_pkg::in_item_t                  in_data,
    output logic                                     out_valid,
    input  wire logic                                out_stall,
    output mutr_pkg::out_item_t                      out_data,
    input  wire logic                                cfg_we,
    input  wire logic                                cfg_index,
    input  wire logic [mutr_pkg::CFG_DATA_W-1:0]     cfg_data
);

    localparam int AW = $clog2(MAX_WIDTH);
    localparam int CW = $clog2(MAX_WIDTH + 1);
    localparam int XW = (CW > 9) ? CW : 9;
    localparam int ACC_W  = mutr_pkg::ACC_W;
    localparam int QMAG_W = mutr_pkg::QMAG_W;
    localparam int DEN_W  = mutr_pkg::DEN_W;
    localparam int PROD_W = mutr_pkg::PROD_W;

    localparam logic [2:0] S_CLEAR = 3'd0;
    localparam logic [2:0] S_IDLE  = 3'd1;
    localparam logic [2:0] S_READ  = 3'd2;
    localparam logic [2:0] S_MUL   = 3'd3;
    localparam logic [2:0] S_SIGN  = 3'd4;
    localparam logic [2:0] S_DIV   = 3'd5;
    localparam logic [2:0] S_SAT   = 3'd6;
    localparam logic [2:0] S_EMIT  = 3'd7;

    logic [2:0]          state_reg;
    logic [AW-1:0]       clr_addr_reg;
    logic [8:0]          gw_reg;
    logic [15:0]         gh_reg;
    logic [CW-1:0]       col_reg;
    logic [15:0]         row_reg;
    mutr_pkg::in_item_t  cur_reg;
    logic [CW-1:0]       c_reg;
    logic [15:0]         r_reg;
    logic [31:0]         prev_value_reg;
    logic                prev_mask_reg;
    logic [63:0]         prev_weights_reg;
    logic                prev_tmask_reg;
    logic [32:0]         prev_above_reg;
    logic signed [31:0]  val_reg [4];
    logic [15:0]         wt_reg [4];
    logic [1:0]          step_reg;
    logic signed [ACC_W-1:0] acc_reg;
    logic [QMAG_W-1:0]   qmag_reg;
    logic [DEN_W-1:0]    rem_reg;
    logic [DEN_W-1:0]    den_reg;
    logic [5:0]          div_cnt_reg;
    logic                neg_reg;
    logic                emit_a_reg;
    logic                emit_b_reg;
    logic [31:0]         tv_reg;
    mutr_pkg::out_item_t q0_reg;
    mutr_pkg::out_item_t q1_reg;
    logic [1:0]          qcnt_reg;

    logic [XW-1:0]       wc;
    logic [CW-1:0]       wc_last;
    logic [15:0]         hc;
    logic [CW-1:0]       c_in;
    logic [15:0]         r_in;
    logic                accept;
    logic                pop;
    logic                ram_we;
    logic [AW-1:0]       ram_waddr;
    logic [32:0]         ram_wdata;
    logic [32:0]         above;
    logic [DEN_W-1:0]    den;
    logic signed [PROD_W-1:0] prod;
    logic signed [ACC_W-1:0]  acc_neg;
    logic [DEN_W:0]      trial;
    logic                trial_ge;
    logic [16:0]         row_inc;
    logic [15:0]         col_ext_a;
    logic [15:0]         col_ext_b;
    mutr_pkg::out_item_t res_a;
    mutr_pkg::out_item_t res_b;

    always_comb
    begin
        wc = XW'(gw_reg);
        if (wc < XW'(2))
        begin
            wc = XW'(2);
        end
        else if (wc > XW'(MAX_WIDTH))
        begin
            wc = XW'(MAX_WIDTH);
        end
        wc_last = CW'(wc - XW'(1));
        hc = (gh_reg < 16'd2) ? 16'd2 : gh_reg;
        c_in = (XW'(col_reg) >= wc) ? wc_last : col_reg;
        r_in = (row_reg >= hc) ? 16'd0 : row_reg;
    end

    assign accept    = in_valid && !in_stall;
    assign in_stall  = !(state_reg == S_IDLE && qcnt_reg == 2'd0);
    assign out_valid = (qcnt_reg != 2'd0);
    assign out_data  = q0_reg;
    assign pop       = out_valid && !out_stall;

    assign ram_we    = (state_reg == S_CLEAR) || (state_reg == S_READ);
    assign ram_waddr = (state_reg == S_CLEAR) ? clr_addr_reg : c_reg[AW-1:0];
    assign ram_wdata = (state_reg == S_CLEAR) ? 33'd0 : {cur_reg.u_mask, cur_reg.u_value};

    mutr_ram #(
        .WIDTH(33),
        .DEPTH(MAX_WIDTH)
    ) u_line_ram (
        .clk  (clk),
        .we   (ram_we),
        .waddr(ram_waddr),
        .wdata(ram_wdata),
        .raddr(c_in[AW-1:0]),
        .rdata(above)
    );

    assign den = (prev_mask_reg ? DEN_W'(prev_weights_reg[15:0]) : DEN_W'(0))
               + (prev_above_reg[32] ? DEN_W'(prev_weights_reg[31:16]) : DEN_W'(0))
               + (cur_reg.u_mask ? DEN_W'(prev_weights_reg[47:32]) : DEN_W'(0))
               + (above[32] ? DEN_W'(prev_weights_reg[63:48]) : DEN_W'(0));

    assign prod     = $signed({1'b0, wt_reg[step_reg]}) * val_reg[step_reg];
    assign acc_neg  = -acc_reg;
    assign trial    = {rem_reg, qmag_reg[QMAG_W-1]};
    assign trial_ge = (trial >= {1'b0, den_reg});
    assign row_inc  = {1'b0, r_reg} + 17'd1;
    assign col_ext_a = 16'(c_reg - CW'(1));
    assign col_ext_b = 16'(c_reg);

    always_comb
    begin
        res_a.t_value     = tv_reg;
        res_a.row_index   = r_reg;
        res_a.col_index   = col_ext_a[7:0];
        res_a.last_of_row = 1'b0;
        res_b.t_value     = 32'sd0;
        res_b.row_index   = r_reg;
        res_b.col_index   = col_ext_b[7:0];
        res_b.last_of_row = 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= S_CLEAR;
            clr_addr_reg     <= '0;
            gw_reg           <= mutr_pkg::GRID_WIDTH_RST;
            gh_reg           <= mutr_pkg::GRID_HEIGHT_RST;
            col_reg          <= '0;
            row_reg          <= '0;
            cur_reg          <= '0;
            c_reg            <= '0;
            r_reg            <= '0;
            prev_value_reg   <= '0;
            prev_mask_reg    <= 1'b0;
            prev_weights_reg <= '0;
            prev_tmask_reg   <= 1'b0;
            prev_above_reg   <= '0;
            for (int i = 0; i < 4; i++)
            begin
                val_reg[i] <= '0;
                wt_reg[i]  <= '0;
            end
            step_reg         <= '0;
            acc_reg          <= '0;
            qmag_reg         <= '0;
            rem_reg          <= '0;
            den_reg          <= '0;
            div_cnt_reg      <= '0;
            neg_reg          <= 1'b0;
            emit_a_reg       <= 1'b0;
            emit_b_reg       <= 1'b0;
            tv_reg           <= '0;
            q0_reg           <= '0;
            q1_reg           <= '0;
            qcnt_reg         <= '0;
        end
        else
        begin
            if (pop)
            begin
                q0_reg   <= q1_reg;
                qcnt_reg <= qcnt_reg - 2'd1;
            end

            unique case (state_reg)
                S_CLEAR:
                begin
                    clr_addr_reg <= clr_addr_reg + AW'(1);
                    if (clr_addr_reg == AW'(MAX_WIDTH - 1))
                    begin
                        state_reg <= S_IDLE;
                    end
                end
                S_IDLE:
                begin
                    if (accept)
                    begin
                        cur_reg   <= in_data;
                        c_reg     <= c_in;
                        r_reg     <= r_in;
                        state_reg <= S_READ;
                    end
                end
                S_READ:
                begin
                    val_reg[0] <= $signed(prev_value_reg);
                    val_reg[1] <= $signed(prev_above_reg[31:0]);
                    val_reg[2] <= cur_reg.u_value;
                    val_reg[3] <= $signed(above[31:0]);
                    wt_reg[0]  <= prev_weights_reg[15:0];
                    wt_reg[1]  <= prev_weights_reg[31:16];
                    wt_reg[2]  <= prev_weights_reg[47:32];
                    wt_reg[3]  <= prev_weights_reg[63:48];
                    den_reg    <= den;
                    emit_a_reg <= (c_reg != '0);
                    emit_b_reg <= (c_reg == wc_last);
                    tv_reg     <= '0;
                    step_reg   <= '0;
                    acc_reg    <= '0;
                    prev_value_reg   <= cur_reg.u_value;
                    prev_mask_reg    <= cur_reg.u_mask;
                    prev_tmask_reg   <= cur_reg.t_mask;
                    prev_weights_reg <= {cur_reg.weight_northeast, cur_reg.weight_east,
                                         cur_reg.weight_north, cur_reg.weight_here};
                    prev_above_reg   <= above;
                    if (c_reg != '0 && r_reg != 16'd0 && prev_tmask_reg && den != '0)
                    begin
                        state_reg <= S_MUL;
                    end
                    else
                    begin
                        state_reg <= S_EMIT;
                    end
                end
                S_MUL:
                begin
                    acc_reg  <= acc_reg + ACC_W'(prod);
                    step_reg <= step_reg + 2'd1;
                    if (step_reg == 2'd3)
                    begin
                        state_reg <= S_SIGN;
                    end
                end
                S_SIGN:
                begin
                    neg_reg     <= acc_reg[ACC_W-1];
                    qmag_reg    <= acc_reg[ACC_W-1] ? QMAG_W'(acc_neg) : QMAG_W'(acc_reg);
                    rem_reg     <= '0;
                    div_cnt_reg <= '0;
                    state_reg   <= S_DIV;
                end
                S_DIV:
                begin
                    rem_reg     <= trial_ge ? DEN_W'(trial - {1'b0, den_reg}) : trial[DEN_W-1:0];
                    qmag_reg    <= {qmag_reg[QMAG_W-2:0], trial_ge};
                    div_cnt_reg <= div_cnt_reg + 6'd1;
                    if (div_cnt_reg == 6'(QMAG_W - 1))
                    begin
                        state_reg <= S_SAT;
                    end
                end
                S_SAT:
                begin
                    if (!neg_reg)
                    begin
                        tv_reg <= (qmag_reg > QMAG_W'(32'h7FFF_FFFF)) ? 32'h7FFF_FFFF
                                                                    : qmag_reg[31:0];
                    end
                    else
                    begin
                        tv_reg <= (qmag_reg > QMAG_W'(32'h8000_0000)) ? 32'h8000_0000
                                                                    : ~qmag_reg[31:0] + 32'd1;
                    end
                    state_reg <= S_EMIT;
                end
                S_EMIT:
                begin
                    if (emit_a_reg && emit_b_reg)
                    begin
                        q0_reg   <= res_a;
                        q1_reg   <= res_b;
                        qcnt_reg <= 2'd2;
                    end
                    else if (emit_a_reg)
                    begin
                        q0_reg   <= res_a;
                        qcnt_reg <= 2'd1;
                    end
                    else if (emit_b_reg)
                    begin
                        q0_reg   <= res_b;
                        qcnt_reg <= 2'd1;
                    end
                    state_reg <= S_IDLE;
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase

            if (cfg_we)
            begin
                if (cfg_index == mutr_pkg::CFG_GRID_WIDTH)
                begin
                    gw_reg <= cfg_data[8:0];
                end
                else
                begin
                    gh_reg <= cfg_data;
                end
            end

            if (cfg_we)
            begin
                col_reg <= '0;
                row_reg <= '0;
            end
            else if (state_reg == S_READ)
            begin
                if (c_reg == wc_last)
                begin
                    col_reg <= '0;
                    row_reg <= (row_inc >= {1'b0, hc}) ? 16'd0 : row_inc[15:0];
                end
                else
                begin
                    col_reg <= c_reg + CW'(1);
                end
            end
        end
    end

endmodule
`default_nettype wire

// ----- rtl/core/mutr_checker.sv -----
`default_nettype none
module mutr_checker (
    input wire logic                            clk,
    input wire logic                            rst_n,
    input wire logic                            in_valid,
    input wire logic                            in_stall,
    input wire logic                            out_valid,
    input wire logic                            out_stall,
    input wire mutr_pkg::out_item_t             out_data
);

    a_in_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_stall |=> in_stall)
        else $error("input accepted while a transaction is in flight");

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid)
        else $error("output transaction dropped while stalled");

    a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> $stable(out_data))
        else $error("stalled output payload changed");

    a_last_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_data.last_of_row |-> out_data.t_value == 32'sd0)
        else $error("last column target value is not zero");

    a_row0_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_data.row_index == 16'd0 |-> out_data.t_value == 32'sd0)
        else $error("row zero target value is not zero");

endmodule

bind masked_ugrid_to_tgrid_remap_unit mutr_checker u_mutr_checker (.*);
`default_nettype wire
